### hdl/totp_pkg.sv
`default_nettype none
package totp_pkg;
	localparam int KeyUpperWidth = 64;
	localparam int KeyLowerWidth = 32;
	localparam int DigitWidth = 4;
	localparam int StepWidth = 32;
	localparam int TimeWidth = 64;
	localparam int CodeWidth = 30;
	localparam int TruncWidth = 31;
	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth = 64;
	localparam int DigestWidth = 160;
	localparam int BlockWidth = 512;

	localparam logic [CfgIndexWidth-1:0] REG_KEY_UPPER = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_KEY_MIDDLE = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_KEY_LOWER = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_DIGIT_COUNT = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_STEP_SECONDS = 3'd4;

	localparam logic [DigitWidth-1:0] DigitReset = 4'd6;
	localparam logic [StepWidth-1:0] StepReset = 32'd30;

	localparam logic [DigestWidth-1:0] ShaInit =
		160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_LOAD, ST_HASH, ST_NEXT, ST_TRUNC, ST_MOD, ST_OUT
	} state_t;

	// which block the hash unit is fed with
	typedef enum logic [1:0] {
		BLK_INNER1, BLK_INNER2, BLK_OUTER1, BLK_OUTER2
	} blk_sel_t;

	typedef struct packed {
		logic     div_start;
		logic     load_block;
		blk_sel_t blk;
		logic     hash_step;
		logic     hash_finish;
		logic     trunc_load;
		logic     mod_start;
		logic     out_load;
	} totp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic round_last;
		logic mod_done;
	} totp_sts_t;

	function automatic logic [31:0] pow10(input logic [DigitWidth-1:0] d);
		case (d)
			4'd0, 4'd1: pow10 = 32'd10;
			4'd2: pow10 = 32'd100;
			4'd3: pow10 = 32'd1000;
			4'd4: pow10 = 32'd10000;
			4'd5: pow10 = 32'd100000;
			4'd6: pow10 = 32'd1000000;
			4'd7: pow10 = 32'd10000000;
			4'd8: pow10 = 32'd100000000;
			default: pow10 = 32'd1000000000;
		endcase
	endfunction
endpackage
`default_nettype wire

### hdl/totp_hmac_sha1_code_generator.sv
// an item passes through the divider, four sha-1 blocks, the truncation, the modulo
// reduction and the output load; a new item is taken only once the last one has reached
// the output stage; one item is taken while a result waits, then the input stalls until
// the result leaves
// reset: asynchronous active-low, key clears to zero, digits 6, step 30 seconds
`default_nettype none
module totp_hmac_sha1_code_generator (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [totp_pkg::CfgIndexWidth-1:0]    cfg_index,
	input  wire logic [totp_pkg::CfgDataWidth-1:0]     cfg_data,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [63:0]                           s_tdata, // unix_seconds
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// otp_code[29:0], truncated_value[60:30], time_counter[124:61], zeros
	output logic [127:0]                               m_tdata
);
	import totp_pkg::*;

	logic [KeyUpperWidth-1:0] key_upper_q, key_middle_q;
	logic [KeyLowerWidth-1:0] key_lower_q;
	logic [DigitWidth-1:0] digit_q;
	logic [StepWidth-1:0] step_q;
	totp_cmd_t cmd;
	totp_sts_t sts;
	logic busy;
	logic [CodeWidth-1:0] otp_code;
	logic [TruncWidth-1:0] truncated_value;
	logic [TimeWidth-1:0] time_counter;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_middle_q <= '0;
			key_lower_q <= '0;
			digit_q <= DigitReset;
			step_q <= StepReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_UPPER: key_upper_q <= cfg_data;
				REG_KEY_MIDDLE: key_middle_q <= cfg_data;
				REG_KEY_LOWER: key_lower_q <= cfg_data[KeyLowerWidth-1:0];
				REG_DIGIT_COUNT: digit_q <= cfg_data[DigitWidth-1:0];
				REG_STEP_SECONDS: step_q <= cfg_data[StepWidth-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !busy;

	totp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
	);

	totp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.unix_seconds(s_tdata),
		.key({key_upper_q, key_middle_q, key_lower_q}),
		.digit_count(digit_q), .step_seconds(step_q),
		.otp_code(otp_code), .truncated_value(truncated_value),
		.time_counter(time_counter)
	);

	assign m_tdata = {3'd0, time_counter, truncated_value, otp_code};
endmodule
`default_nettype wire

### hdl/totp_ctrl.sv
`default_nettype none
module totp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_fire,
	input  wire logic                out_fire,
	input  wire totp_pkg::totp_sts_t sts,
	output totp_pkg::totp_cmd_t      cmd,
	output logic                     busy,
	output logic                     out_valid
);
	import totp_pkg::*;

	state_t state_q, state_d;
	blk_sel_t blk_q, blk_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blk_q <= BLK_INNER1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			blk_q <= blk_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		blk_d = blk_q;
		cmd = '0;
		cmd.blk = blk_q;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					blk_d = BLK_INNER1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_block = 1'b1;
				state_d = ST_HASH;
			end
			ST_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.round_last) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.hash_finish = 1'b1;
				case (blk_q)
					BLK_INNER1: begin blk_d = BLK_INNER2; state_d = ST_LOAD; end
					BLK_INNER2: begin blk_d = BLK_OUTER1; state_d = ST_LOAD; end
					BLK_OUTER1: begin blk_d = BLK_OUTER2; state_d = ST_LOAD; end
					default: state_d = ST_TRUNC;
				endcase
			end
			ST_TRUNC: begin
				cmd.trunc_load = 1'b1;
				state_d = ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				// wait here while the output register still holds the previous item
				if (!out_valid_q || out_fire) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.mod_start = (state_q == ST_TRUNC);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE)
		else $error("item taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_fire |=> out_valid_q)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_fire)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> state_q == ST_HASH)
		else $error("load not followed by rounds");
endmodule
`default_nettype wire

### hdl/totp_datapath.sv
`default_nettype none
module totp_datapath (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire totp_pkg::totp_cmd_t                    cmd,
	output totp_pkg::totp_sts_t                         sts,
	input  wire logic [totp_pkg::TimeWidth-1:0]         unix_seconds,
	input  wire logic [159:0]                           key,
	input  wire logic [totp_pkg::DigitWidth-1:0]        digit_count,
	input  wire logic [totp_pkg::StepWidth-1:0]         step_seconds,
	output logic [totp_pkg::CodeWidth-1:0]              otp_code,
	output logic [totp_pkg::TruncWidth-1:0]             truncated_value,
	output logic [totp_pkg::TimeWidth-1:0]              time_counter
);
	import totp_pkg::*;

	// restoring divider, one quotient bit a cycle
	logic [TimeWidth-1:0] quo_q;
	logic [StepWidth:0] rem_q;
	logic [StepWidth-1:0] div_q;
	logic [6:0] div_cnt_q;
	logic div_busy_q;
	logic [StepWidth:0] rem_sh;
	logic rem_ge;

	assign rem_sh = {rem_q[StepWidth-1:0], quo_q[TimeWidth-1]};
	assign rem_ge = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 7'd0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 7'd1;
			if (div_cnt_q == 7'(TimeWidth - 1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= unix_seconds;
			rem_q <= '0;
			div_q <= (step_seconds == '0) ? StepWidth'(1) : step_seconds;
		end else if (div_busy_q) begin
			rem_q <= rem_ge ? rem_sh - {1'b0, div_q} : rem_sh;
			quo_q <= {quo_q[TimeWidth-2:0], rem_ge};
		end
	end
	assign sts.div_done = !div_busy_q && !cmd.div_start;

	// sha-1 round engine with a 16-word schedule window
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [DigestWidth-1:0] h_q, inner_q;
	logic [6:0] rnd_q;
	logic [BlockWidth-1:0] blk;
	logic [511:0] ipad, opad;
	logic [31:0] f, k, t, wn;

	always_comb begin
		ipad = {key ^ {20{8'h36}}, {44{8'h36}}};
		opad = {key ^ {20{8'h5c}}, {44{8'h5c}}};
		case (cmd.blk)
			BLK_INNER1, BLK_OUTER1: blk = (cmd.blk == BLK_INNER1) ? ipad : opad;
			BLK_INNER2: blk = {quo_q, 8'h80, 376'd0, 64'd576};
			default: blk = {inner_q, 8'h80, 280'd0, 64'd672};
		endcase
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5a827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ed9eba1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8f1bbcdc;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hca62c1d6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wn = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wn = {wn[30:0], wn[31]};
	end
	assign sts.round_last = (rnd_q == 7'd79);

	always_ff @(posedge clk) begin
		if (cmd.load_block) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[511 - 32*i -: 32];
			if (cmd.blk == BLK_INNER1 || cmd.blk == BLK_OUTER1) begin
				h_q <= ShaInit;
				{a_q, b_q, c_q, d_q, e_q} <= ShaInit;
			end else
				{a_q, b_q, c_q, d_q, e_q} <= h_q;
			rnd_q <= '0;
		end else if (cmd.hash_step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q; a_q <= t;
			rnd_q <= rnd_q + 7'd1;
		end else if (cmd.hash_finish) begin
			h_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
				h_q[63:32] + d_q, h_q[31:0] + e_q};
			if (cmd.blk == BLK_INNER2)
				inner_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q,
					h_q[95:64] + c_q, h_q[63:32] + d_q, h_q[31:0] + e_q};
		end
	end

	// dynamic truncation then a shift-subtract reduction
	logic [TruncWidth-1:0] trunc_q;
	logic [3:0] off;
	logic [31:0] word;
	logic [61:0] mrem_q, mdiv_q;
	logic [5:0] mcnt_q;
	logic mbusy_q;

	assign off = h_q[3:0];
	assign word = h_q[159 - 8*off -: 32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q <= '0;
		end else if (cmd.mod_start) begin
			mbusy_q <= 1'b1;
			mcnt_q <= '0;
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q + 6'd1;
			if (mcnt_q == 6'd30) mbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.trunc_load) trunc_q <= word[30:0];
		// truncation and reduction start on the same edge, so take the word directly
		if (cmd.mod_start) begin
			mrem_q <= {31'd0, word[30:0]};
			mdiv_q <= {pow10(digit_count > 4'd9 ? 4'd9 : digit_count)
				, 30'd0};
		end else if (mbusy_q) begin
			if (mrem_q >= mdiv_q) mrem_q <= mrem_q - mdiv_q;
			mdiv_q <= {1'b0, mdiv_q[61:1]};
		end
	end
	assign sts.mod_done = !mbusy_q && !cmd.mod_start;

	// output register, frees the datapath for the next item
	logic [CodeWidth-1:0] code_out_q;
	logic [TruncWidth-1:0] trunc_out_q;
	logic [TimeWidth-1:0] ctr_out_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			code_out_q <= mrem_q[CodeWidth-1:0];
			trunc_out_q <= trunc_q;
			ctr_out_q <= quo_q;
		end
	end
	assign otp_code = code_out_q;
	assign truncated_value = trunc_out_q;
	assign time_counter = ctr_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hash_step |-> rnd_q <= 7'd79)
		else $error("round counter overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> div_q != '0)
		else $error("zero divisor");
	assert property (@(posedge clk) disable iff (!arst_n)
		mbusy_q && mcnt_q == 6'd30 |=> !mbusy_q)
		else $error("modulo overran");
endmodule
`default_nettype wire

### tb/totp_code_checker.sv
`default_nettype none
module totp_code_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [totp_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wire logic [totp_pkg::CfgDataWidth-1:0]  cfg_data,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	input  wire logic [63:0]                        s_tdata,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic [127:0]                       m_tdata,
	output int                                      errors,
	output int                                      pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import totp_pkg::*;

	typedef struct packed {
		logic [CodeWidth-1:0]  code;
		logic [TruncWidth-1:0] trunc;
		logic [TimeWidth-1:0]  counter;
	} otp_result_t;

	logic [63:0] key_upper_q, key_middle_q;
	logic [31:0] key_lower_q;
	logic [3:0]  digits_q;
	logic [31:0] step_q;
	otp_result_t code_q[$];

	assign pending = code_q.size();

	function automatic logic [159:0] sha1_compress(input logic [159:0] h,
			input logic [511:0] blk);
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int i;
		for (i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
		for (i = 16; i < 80; i++) begin
			x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {x[30:0], x[31]};
		end
		a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5a827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ed9eba1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
			end else begin
				f = b ^ c ^ d; k = 32'hca62c1d6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
		end
		return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
	endfunction

	function automatic otp_result_t predict_code(input logic [63:0] unix_t);
		otp_result_t r;
		logic [63:0]  step, ctr;
		logic [3:0]   dg;
		logic [159:0] key, inner, outer;
		logic [511:0] padded;
		logic [3:0]   off;
		logic [31:0]  tr, modulus;
		int i;
		step = (step_q == 0) ? 64'd1 : {32'd0, step_q};
		ctr = unix_t / step;
		dg = (digits_q < 1) ? 4'd1 : (digits_q > 9) ? 4'd9 : digits_q;
		modulus = 1;
		for (i = 0; i < dg; i++) modulus = modulus * 10;
		key = {key_upper_q, key_middle_q, key_lower_q};
		padded = {key, 352'd0};
		inner = sha1_compress(ShaInit, padded ^ {64{8'h36}});
		inner = sha1_compress(inner, {ctr, 8'h80, 376'd0, 64'd576});
		outer = sha1_compress(ShaInit, padded ^ {64{8'h5c}});
		outer = sha1_compress(outer, {inner, 8'h80, 280'd0, 64'd672});
		off = outer[3:0];
		tr = outer[159-8*off -: 32] & 32'h7fffffff;
		r.code = CodeWidth'(tr % modulus);
		r.trunc = tr[30:0];
		r.counter = ctr;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		otp_result_t got, want;
		if (!arst_n) begin
			key_upper_q = '0;
			key_middle_q = '0;
			key_lower_q = '0;
			digits_q = DigitReset;
			step_q = StepReset;
			code_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_UPPER:    key_upper_q = cfg_data;
					REG_KEY_MIDDLE:   key_middle_q = cfg_data;
					REG_KEY_LOWER:    key_lower_q = cfg_data[31:0];
					REG_DIGIT_COUNT:  digits_q = cfg_data[3:0];
					REG_STEP_SECONDS: step_q = cfg_data[31:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) code_q.push_back(predict_code(s_tdata));
			if (m_tvalid && m_tready) begin
				got.code = m_tdata[29:0];
				got.trunc = m_tdata[60:30];
				got.counter = m_tdata[124:61];
				if (code_q.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					want = code_q.pop_front();
					if (got.code !== want.code) begin
						$error("otp_code: expected %0d, got %0d", want.code, got.code);
						errors++;
					end
					if (got.trunc !== want.trunc) begin
						$error("truncated_value: expected %0h, got %0h", want.trunc, got.trunc);
						errors++;
					end
					if (got.counter !== want.counter) begin
						$error("time_counter: expected %0h, got %0h", want.counter, got.counter);
						errors++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### tb/totp_hmac_sha1_code_generator_tb.sv
`default_nettype none
module totp_hmac_sha1_code_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import totp_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int DrainCycles = 500;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	int           errors, pending;
	int           send_idle = 0, recv_idle = 0;
	int           cycles = 0, hold_left = 0;
	bit           press_req = 0, press_done = 0;

	totp_hmac_sha1_code_generator dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
	);

	totp_code_checker checker_i (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.errors, .pending
	);

	always #6 clk = ~clk;

	// receiver, with one long hold-off so the block stalls its input
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (press_req && !press_done) begin
			press_done = 1;
			hold_left = 3000;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_time(input logic [63:0] unix_t);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= unix_t;
		do @(posedge clk); while (!s_tready);
	endtask

	// wait on the clock first so the checker has seen the last item taken
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// cfg_we stays high across a burst, lowered once by end_writes
	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_time();
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: return {32'd0, $urandom};
			2: return 64'($urandom_range(1000));
			default: return {32'hffffffff, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_step();
		case ($urandom_range(6))
			0: return {$urandom, 32'd0};
			1: return {$urandom, 32'd1};
			2: return 64'd30;
			3: return {$urandom, 32'hffffffff};
			4: return {$urandom, $urandom_range(1, 100)};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int ph, blk, n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero key, six digits, thirty seconds
		push_time(64'd0);
		push_time(64'd59);
		push_time(64'hffffffffffffffff);
		push_time(64'd1111111109);
		wait_idle();

		write_reg(REG_KEY_UPPER, 64'h3132333435363738);
		write_reg(REG_KEY_MIDDLE, 64'h3930313233343536);
		write_reg(REG_KEY_LOWER, 64'hdeadbeef37383930);
		write_reg(REG_DIGIT_COUNT, 64'd8);
		end_writes();
		push_time(64'd59);
		push_time(64'd1111111109);
		push_time(64'd1234567890);
		push_time(64'd20000000000);
		wait_idle();

		// zero step period and zero digit count
		write_reg(REG_KEY_UPPER, '1);
		write_reg(REG_KEY_MIDDLE, '1);
		write_reg(REG_KEY_LOWER, '1);
		write_reg(REG_DIGIT_COUNT, 64'hfffffffffffffff0);
		write_reg(REG_STEP_SECONDS, 64'hffffffff00000000);
		end_writes();
		push_time(64'd0);
		push_time(64'hffffffffffffffff);
		push_time(64'h8000000000000001);
		wait_idle();

		// digit count above nine, unit step, unused indexes
		write_reg(REG_DIGIT_COUNT, 64'd15);
		write_reg(REG_STEP_SECONDS, 64'd1);
		write_reg(3'd5, '1);
		write_reg(3'd6, '1);
		write_reg(3'd7, '1);
		end_writes();
		push_time(64'hffffffffffffffff);
		push_time(64'd1);
		wait_idle();

		write_reg(REG_DIGIT_COUNT, 64'd9);
		write_reg(REG_STEP_SECONDS, 64'hffffffff);
		end_writes();
		push_time(64'hffffffffffffffff);
		push_time(64'hffffffff);
		push_time(64'hfffffffe);
		wait_idle();

		write_reg(REG_DIGIT_COUNT, 64'd10);
		end_writes();
		push_time(64'h00000000ffffffff);
		wait_idle();
		write_reg(REG_DIGIT_COUNT, 64'd1);
		end_writes();
		push_time(64'haaaaaaaa55555555);
		wait_idle();

		for (ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
			recv_idle = (ph == 0) ? 78 : (ph == 1) ? 17 : 0;
			for (blk = 0; blk < 6; blk++) begin
				write_reg(REG_KEY_UPPER, {$urandom, $urandom});
				write_reg(REG_KEY_MIDDLE, {$urandom, $urandom});
				write_reg(REG_KEY_LOWER, {$urandom, $urandom});
				write_reg(REG_DIGIT_COUNT, {$urandom, 28'd0, 4'($urandom_range(15))});
				write_reg(REG_STEP_SECONDS, rand_step());
				end_writes();
				if (ph == 2 && blk == 1) press_req = 1;
				for (n = 0; n < 30; n++) push_time(rand_time());
				wait_idle();
			end
		end

		wait_idle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
